### rtl/ccgh_pkg.sv
package ccgh_pkg;

    localparam int ChanW   = 8;
    localparam int DivOpW  = 11;   // operands up to 6 * 255
    localparam int FracW   = 16;
    localparam int QuoW    = FracW + 1;
    localparam int DivSteps = QuoW;

    localparam logic [ChanW-1:0] TolReset = 8'd10;

    localparam logic [0:0] RegColorTolerance = 1'b0;

    typedef struct packed {
        logic [ChanW-1:0] red_in;
        logic [ChanW-1:0] green_in;
        logic [ChanW-1:0] blue_in;
    } rgb_t;

    typedef struct packed {
        logic [FracW-1:0] hue_frac;
        logic [QuoW-1:0]  saturation_frac;
        logic [ChanW-1:0] value_level;
    } hsv_t;

    // request to the shared divider: quotient = floor(num * 2^16 / den), num <= den
    typedef struct packed {
        logic              start;
        logic [DivOpW-1:0] num;
        logic [DivOpW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [QuoW-1:0] quo;
    } div_res_t;

endpackage

### rtl/color_change_gated_rgb_to_hsv.sv
// Channel   | Handshake                       | Payload
// ----------+---------------------------------+------------------------------
// sample    | sample_valid / sample_ready     | ccgh_pkg::rgb_t (r, g, b)
// hsv       | hsv_valid / hsv_ready           | ccgh_pkg::hsv_t (hue, sat, val)
// apb       | psel, penable, pwrite, pready=1 | paddr[2:0], pwdata, prdata
//
// A sample within tolerance of the stored one is dropped in its accept cycle;
// the block is ready again the next cycle.
// A changed sample keeps sample_ready low through the prep state, two
// 17-step divisions (hue, then saturation) on the single restoring divider,
// and the emit state, which waits for the output register to be free.
// sample_ready is low while a transaction is in work; a result waits in the
// output register, so a new sample is taken while hsv is stalled, and only
// the next result waits for it to drain.
// Reset (rst_n, async) clears the stored sample to black and the tolerance to 10.
module color_change_gated_rgb_to_hsv (
    input  logic               clk,
    input  logic               rst_n,
    // sample channel
    input  logic               sample_valid,
    output logic               sample_ready,
    input  ccgh_pkg::rgb_t     sample,
    // result channel
    output logic               hsv_valid,
    input  logic               hsv_ready,
    output ccgh_pkg::hsv_t     hsv,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_HUE,
        ST_SAT,
        ST_EMIT
    } state_t;

    localparam int CW = ccgh_pkg::ChanW;
    localparam int DW = ccgh_pkg::DivOpW;

    state_t             state_reg;
    logic [CW-1:0]      tol_reg;
    logic [CW-1:0]      last_red_reg;
    logic [CW-1:0]      last_green_reg;
    logic [CW-1:0]      last_blue_reg;
    logic [CW-1:0]      red_reg;
    logic [CW-1:0]      green_reg;
    logic [CW-1:0]      blue_reg;
    logic [CW-1:0]      chroma_reg;
    logic [CW-1:0]      value_reg;
    logic [ccgh_pkg::FracW-1:0] hue_reg;
    logic               hsv_valid_reg;
    ccgh_pkg::hsv_t     hsv_reg;
    // payload shown to the consumer; hsv_reg may be refilled while it is held
    ccgh_pkg::hsv_t     hsv_out_reg;

    ccgh_pkg::div_req_t div_req;
    ccgh_pkg::div_res_t div_res;

    logic               sample_take;
    logic               changed;
    logic               cfg_write;
    logic               cfg_hit;
    logic [CW-1:0]      v_max;
    logic [CW-1:0]      v_min;
    logic [CW-1:0]      chroma;
    logic [DW-1:0]      chroma6;
    logic [DW-1:0]      hue_num;
    logic               out_free;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    assign sample_ready = (state_reg == ST_IDLE);
    assign sample_take  = sample_valid && sample_ready;

    // color-change gate
    assign changed = (abs_diff(last_red_reg,   sample.red_in)   >= tol_reg) ||
                     (abs_diff(last_green_reg, sample.green_in) >= tol_reg) ||
                     (abs_diff(last_blue_reg,  sample.blue_in)  >= tol_reg);

    // APB: single register at byte address 0
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == ccgh_pkg::RegColorTolerance);
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign prdata    = cfg_hit ? {{(32-CW){1'b0}}, tol_reg} : 32'd0;

    // max, min, chroma and hue numerator from the held sample
    always_comb
    begin
        v_max = red_reg;
        if (green_reg > v_max) v_max = green_reg;
        if (blue_reg > v_max)  v_max = blue_reg;
        v_min = red_reg;
        if (green_reg < v_min) v_min = green_reg;
        if (blue_reg < v_min)  v_min = blue_reg;
        chroma  = v_max - v_min;
        chroma6 = {1'b0, chroma, 2'b00} + {2'b00, chroma, 1'b0};

        // numerator is folded into [0, 6C): a negative red-sector value gets
        // one full turn added, which equals the wrap of the quotient
        if (red_reg == v_max)
        begin
            if (green_reg >= blue_reg)
                hue_num = {3'b000, green_reg - blue_reg};
            else
                hue_num = chroma6 - {3'b000, blue_reg - green_reg};
        end
        else if (green_reg == v_max)
            hue_num = {2'b00, chroma, 1'b0} + {3'b000, blue_reg} - {3'b000, red_reg};
        else
            hue_num = {1'b0, chroma, 2'b00} + {3'b000, red_reg} - {3'b000, green_reg};
    end

    // divider requests: hue from prep, saturation right after hue completes
    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = hue_num;
        div_req.den   = chroma6;
        case (state_reg)
            ST_PREP:
            begin
                div_req.start = 1'b1;
            end
            ST_HUE:
            begin
                div_req.start = div_res.done;
                div_req.num   = {3'b000, chroma_reg};
                div_req.den   = {3'b000, value_reg};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    ccgh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign out_free = !hsv_valid_reg || hsv_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tol_reg        <= ccgh_pkg::TolReset;
            last_red_reg   <= '0;
            last_green_reg <= '0;
            last_blue_reg  <= '0;
            red_reg        <= '0;
            green_reg      <= '0;
            blue_reg       <= '0;
            chroma_reg     <= '0;
            value_reg      <= '0;
            hue_reg        <= '0;
            hsv_valid_reg  <= 1'b0;
            hsv_reg        <= '0;
            hsv_out_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
                tol_reg <= pwdata[CW-1:0];

            // new result goes up as the old one leaves, else valid drops on accept
            if (state_reg == ST_EMIT && out_free)
                hsv_valid_reg <= 1'b1;
            else if (hsv_valid_reg && hsv_ready)
                hsv_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_take && changed)
                    begin
                        last_red_reg   <= sample.red_in;
                        last_green_reg <= sample.green_in;
                        last_blue_reg  <= sample.blue_in;
                        red_reg        <= sample.red_in;
                        green_reg      <= sample.green_in;
                        blue_reg       <= sample.blue_in;
                        state_reg      <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    chroma_reg <= chroma;
                    value_reg  <= v_max;
                    state_reg  <= ST_HUE;
                end
                ST_HUE:
                begin
                    if (div_res.done)
                    begin
                        // grey: hue forced to zero
                        hue_reg   <= (chroma_reg == '0) ? '0
                                   : div_res.quo[ccgh_pkg::FracW-1:0];
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT:
                begin
                    if (div_res.done)
                    begin
                        // black: saturation forced to zero
                        hsv_reg.saturation_frac <= (value_reg == '0) ? '0 : div_res.quo;
                        hsv_reg.hue_frac        <= hue_reg;
                        hsv_reg.value_level     <= value_reg;
                        state_reg               <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        hsv_out_reg <= hsv_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign hsv_valid = hsv_valid_reg;
    assign hsv       = hsv_out_reg;

endmodule

### rtl/ccgh_div.sv
module ccgh_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ccgh_pkg::div_req_t req,
    output ccgh_pkg::div_res_t res
);

    localparam int CntW = $clog2(ccgh_pkg::DivSteps + 1);

    logic [CntW-1:0]               count_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [ccgh_pkg::DivOpW-1:0]   rem_reg;
    logic [ccgh_pkg::DivOpW-1:0]   den_reg;
    logic [ccgh_pkg::QuoW-1:0]     bits_reg;
    logic [ccgh_pkg::QuoW-1:0]     quo_reg;

    logic [ccgh_pkg::DivOpW:0] partial;
    logic [ccgh_pkg::DivOpW:0] trial;
    logic                      fits;

    // one restoring step per cycle
    always_comb
    begin
        partial = {rem_reg, bits_reg[ccgh_pkg::QuoW-1]};
        trial   = partial - {1'b0, den_reg};
        fits    = (partial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            den_reg   <= '0;
            bits_reg  <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                // num <= den, so num >> 1 is already below den
                rem_reg   <= {1'b0, req.num[ccgh_pkg::DivOpW-1:1]};
                bits_reg  <= {req.num[0], {ccgh_pkg::FracW{1'b0}}};
                den_reg   <= req.den;
                quo_reg   <= '0;
                count_reg <= CntW'(ccgh_pkg::DivSteps);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg   <= fits ? trial[ccgh_pkg::DivOpW-1:0]
                                  : partial[ccgh_pkg::DivOpW-1:0];
                quo_reg   <= {quo_reg[ccgh_pkg::QuoW-2:0], fits};
                bits_reg  <= {bits_reg[ccgh_pkg::QuoW-2:0], 1'b0};
                count_reg <= count_reg - CntW'(1);
                if (count_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;

endmodule

### rtl/ccgh_checker.sv
module ccgh_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           hsv_valid,
    input logic           hsv_ready,
    input ccgh_pkg::hsv_t hsv
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hsv_ready |=> hsv_valid && $stable(hsv))
        else $error("result changed while stalled");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> hsv.saturation_frac <= 17'd65536)
        else $error("saturation above one");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv.value_level == 8'd0 |->
            hsv.saturation_frac == 17'd0 && hsv.hue_frac == 16'd0)
        else $error("black sample with nonzero hue or saturation");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv.saturation_frac == 17'd0 |-> hsv.hue_frac == 16'd0)
        else $error("grey sample with nonzero hue");

endmodule

bind color_change_gated_rgb_to_hsv ccgh_checker u_ccgh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hsv_valid (hsv_valid),
    .hsv_ready (hsv_ready),
    .hsv       (hsv)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    // Run limits. A stalled receiver or an idle sender stretches the time a
    // converted color takes in the block. The cycle cap leaves several times
    // the slowest legal run.
    localparam int CycleLimit   = 1_000_000;
    localparam int DrainCycles  = 60;
    localparam int MaxReports   = 10;
    localparam int PerSetting   = 104;
    localparam logic [2:0] TolAddr = 3'(4 * int'(ccgh_pkg::RegColorTolerance));

    logic           clk          = 1'b0;
    logic           rst_n        = 1'b0;
    logic           sample_valid = 1'b0;
    logic           sample_ready;
    ccgh_pkg::rgb_t sample       = '0;
    logic           hsv_valid;
    logic           hsv_ready    = 1'b0;
    ccgh_pkg::hsv_t hsv;
    logic           psel         = 1'b0;
    logic           penable      = 1'b0;
    logic           pwrite       = 1'b0;
    logic [2:0]     paddr        = '0;
    logic [31:0]    pwdata       = '0;
    logic [31:0]    prdata;
    logic           pready;

    // Shadow of the block: the last color that got through the change gate
    // and the tolerance register.
    ccgh_pkg::rgb_t last_color = '0;
    logic [7:0]     tolerance  = ccgh_pkg::TolReset;
    ccgh_pkg::hsv_t expected_hsv[$];

    // Pacing: percent of cycles in which each side holds off.
    int tx_idle_pct = 24;
    int rx_idle_pct = 54;

    int error_count      = 0;
    int samples_sent     = 0;
    int colors_converted = 0;
    int cycle_count      = 0;

    color_change_gated_rgb_to_hsv i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .hsv_valid    (hsv_valid),
        .hsv_ready    (hsv_ready),
        .hsv          (hsv),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_hsv.size());
            $display("tb: errors");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
        hsv_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);

    task automatic log_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        error_count++;
        if (error_count <= MaxReports)
            $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
    endtask

    // Change gate: a sample is a new color when any channel moved by at least
    // the tolerance from the stored one (equal to tolerance counts).
    function automatic bit color_changed(input ccgh_pkg::rgb_t s);
        int dr;
        int dg;
        int db;
        dr = int'(s.red_in)   - int'(last_color.red_in);
        dg = int'(s.green_in) - int'(last_color.green_in);
        db = int'(s.blue_in)  - int'(last_color.blue_in);
        if (dr < 0) dr = -dr;
        if (dg < 0) dg = -dg;
        if (db < 0) db = -db;
        return (dr >= int'(tolerance)) || (dg >= int'(tolerance)) ||
               (db >= int'(tolerance));
    endfunction

    // Exact integer HSV. Hue sector numerator picks red, then green, then blue
    // as the max channel; the quotient is floored and negatives wrap one turn.
    function automatic ccgh_pkg::hsv_t hsv_of(input ccgh_pkg::rgb_t s);
        int             r;
        int             g;
        int             b;
        int             v;
        int             m;
        int             c;
        longint         n;
        longint         q;
        longint         den;
        ccgh_pkg::hsv_t res;
        r = s.red_in;
        g = s.green_in;
        b = s.blue_in;
        v = r;
        if (g > v) v = g;
        if (b > v) v = b;
        m = r;
        if (g < m) m = g;
        if (b < m) m = b;
        c = v - m;
        res = '0;
        res.value_level = v[7:0];
        if (c != 0)
        begin
            if (r == v)
                n = g - b;
            else if (g == v)
                n = 2 * c + b - r;
            else
                n = 4 * c + r - g;
            den = 6 * c;
            if (n >= 0)
                q = (n * 65536) / den;
            else
                q = -((-n * 65536 + den - 1) / den);
            if (q < 0)
                q += 65536;
            if (q >= 65536)
                q = 0;
            res.hue_frac = q[15:0];
        end
        if (v != 0)
            res.saturation_frac = 17'((longint'(c) * 65536) / v);
        return res;
    endfunction

    // One sample transaction. Valid stays up across back-to-back sends and
    // only drops when the sender decides to idle.
    task automatic send_sample(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
        ccgh_pkg::rgb_t s;
        s.red_in   = r;
        s.green_in = g;
        s.blue_in  = b;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        samples_sent++;
        if (color_changed(s))
        begin
            expected_hsv.push_back(hsv_of(s));
            last_color = s;
        end
    endtask

    // Stop sending, let every result drain, then give a dropped sample or a
    // conversion in flight time to settle before touching the register.
    task automatic wait_until_idle();
        sample_valid <= 1'b0;
        while (expected_hsv.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Setup, access, then a return to idle on the bus.
    task automatic apb_transfer(input bit is_write, input logic [31:0] wdata,
                                output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= TolAddr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [7:0] tol);
        logic [31:0] rd;
        wait_until_idle();
        apb_transfer(1'b1, {24'd0, tol}, rd);
        tolerance = tol;
        apb_transfer(1'b0, '0, rd);
        if (rd !== {24'd0, tol})
            log_mismatch("tolerance readback", {24'd0, tol}, rd);
    endtask

    // Register comes out of reset at its documented default.
    task automatic test_register_reset();
        logic [31:0] rd;
        apb_transfer(1'b0, '0, rd);
        if (rd !== {24'd0, ccgh_pkg::TolReset})
            log_mismatch("tolerance after reset", {24'd0, ccgh_pkg::TolReset}, rd);
    endtask

    // Default tolerance: gate boundaries, primaries, grey, black, hue wrap and
    // max-channel priority ties.
    task automatic test_directed_colors();
        send_sample(8'd0,   8'd0,   8'd0);    // same as reset state: dropped
        send_sample(8'd5,   8'd9,   8'd0);    // all below tolerance: dropped
        send_sample(8'd10,  8'd0,   8'd0);    // red moved exactly by tolerance
        send_sample(8'd255, 8'd0,   8'd0);
        send_sample(8'd0,   8'd255, 8'd0);
        send_sample(8'd0,   8'd0,   8'd255);
        send_sample(8'd255, 8'd255, 8'd255);  // grey: zero chroma
        send_sample(8'd0,   8'd0,   8'd0);    // black: zero value
        send_sample(8'd255, 8'd0,   8'd255);  // red/blue tie, negative hue wraps
        send_sample(8'd255, 8'd0,   8'd1);    // just below a full turn
        send_sample(8'd255, 8'd255, 8'd0);    // red/green tie
        send_sample(8'd0,   8'd255, 8'd255);  // green/blue tie
        send_sample(8'd128, 8'd64,  8'd32);
        send_sample(8'd137, 8'd73,  8'd41);   // one short of tolerance: dropped
        send_sample(8'd128, 8'd64,  8'd42);
    endtask

    // Tolerance zero passes every sample, repeats included; 255 only passes a
    // full-scale swing on some channel.
    task automatic test_tolerance_extremes();
        set_tolerance(8'd0);
        send_sample(8'd128, 8'd64,  8'd42);
        send_sample(8'd128, 8'd64,  8'd42);
        send_sample(8'd0,   8'd128, 8'd200);
        set_tolerance(8'd255);
        send_sample(8'd254, 8'd128, 8'd200);  // dropped
        send_sample(8'd255, 8'd128, 8'd200);
        send_sample(8'd1,   8'd255, 8'd0);    // dropped
        send_sample(8'd0,   8'd0,   8'd0);
    endtask

    function automatic logic [7:0] nudge(input logic [7:0] base, input int span);
        int x;
        x = int'(base) + int'($urandom_range(2 * span)) - span;
        if (x < 0) x = 0;
        if (x > 255) x = 255;
        return x[7:0];
    endfunction

    // Random traffic under one pacing mode, swept over several tolerances.
    // Most samples sit close to the stored color so the gate is exercised on
    // both sides of its threshold; the rest are greys and full-range noise.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        logic [7:0] tol;
        int         pick;
        int         span;
        logic [7:0] lvl;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0:       tol = 8'd0;
                1:       tol = 8'd255;
                2:       tol = 8'd1;
                3:       tol = 8'($urandom_range(40, 2));
                4:       tol = 8'($urandom_range(254, 41));
                default: tol = ccgh_pkg::TolReset;
            endcase
            set_tolerance(tol);
            for (int i = 0; i < PerSetting; i++)
            begin
                pick = $urandom_range(99);
                span = int'(tolerance) + 2;
                if (pick < 60)
                    send_sample(nudge(last_color.red_in, span),
                                nudge(last_color.green_in, span),
                                nudge(last_color.blue_in, span));
                else if (pick < 68)
                begin
                    lvl = 8'($urandom_range(255));
                    send_sample(lvl, lvl, lvl);
                end
                else
                    send_sample(8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
            end
        end
    endtask

    // Scoreboard: every result the block hands over is matched, field by
    // field, against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        ccgh_pkg::hsv_t want;
        if (rst_n && hsv_valid && hsv_ready)
        begin
            colors_converted++;
            if (expected_hsv.size() == 0)
                log_mismatch("unexpected result, value_level", 0, hsv.value_level);
            else
            begin
                want = expected_hsv.pop_front();
                if (hsv.hue_frac !== want.hue_frac)
                    log_mismatch("hue_frac", want.hue_frac, hsv.hue_frac);
                if (hsv.saturation_frac !== want.saturation_frac)
                    log_mismatch("saturation_frac", want.saturation_frac,
                                 hsv.saturation_frac);
                if (hsv.value_level !== want.value_level)
                    log_mismatch("value_level", want.value_level, hsv.value_level);
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_colors();
        test_tolerance_extremes();
        // Receiver slow first, then the sender, then full rate both ways.
        test_random_traffic(24, 54);
        test_random_traffic(54, 24);
        test_random_traffic(0, 0);

        wait_until_idle();
        $display("summary: %0d samples sent, %0d colors converted, %0d mismatches",
                 samples_sent, colors_converted, error_count);
        $display("summary: tolerance swept 0..255 under three pacing modes");
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### filelist.f
rtl/ccgh_pkg.sv
rtl/ccgh_div.sv
rtl/color_change_gated_rgb_to_hsv.sv
rtl/ccgh_checker.sv
tb/tb.sv
